// ===== sv/cpa_pkg.sv =====
// Shared constants, types and codon tables for the codon PN/PS accumulator.
package cpa_pkg;

	localparam int PROB_FRAC_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF     = 24;
	localparam int RATE_W             = 48;
	localparam int SUM_W              = 48;
	localparam int CNT_OUT_W          = 24;
	localparam int CFG_REGS           = 4;
	localparam int CFG_IDX_W          = $clog2(CFG_REGS);
	localparam int MUT_PER_CODON      = 9;

	localparam logic [7:0] CHR_MARK = 8'h3E; // '>'
	localparam logic [7:0] CHR_NL   = 8'h0A; // '\n'

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic [7:0] AMINO_STOP = 8'h2A; // '*'

	// Standard genetic code, codon index b1*16 + b2*4 + b3; first char lands in the top byte.
	localparam logic [63:0][7:0] AMINO_OF =
		"KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

	typedef struct packed {
		logic [MUT_PER_CODON-1:0] nonsyn;
		logic [MUT_PER_CODON-1:0] syn;
	} mut_class_t;

	function automatic logic [7:0] amino_of(input logic [5:0] c);
		return AMINO_OF[6'd63 - c];
	endfunction

	// Anything other than ACGT (either case) counts as A.
	function automatic logic [1:0] base_code(input logic [7:0] b);
		logic [1:0] r;
		case (b)
			8'h43, 8'h63: r = BASE_C;
			8'h47, 8'h67: r = BASE_G;
			8'h54, 8'h74: r = BASE_T;
			default:      r = BASE_A;
		endcase
		return r;
	endfunction

	// Bit p*3+s: mutation of base at position p (0 = last base) to the s-th other base.
	function automatic mut_class_t mut_class(input logic [5:0] c);
		mut_class_t r;
		logic [1:0] from;
		logic [1:0] to;
		logic [5:0] other;
		r = '0;
		if (amino_of(c) != AMINO_STOP) begin
			for (int p = 0; p < 3; p++) begin
				from = c[2*p +: 2];
				for (int s = 0; s < 3; s++) begin
					to = (2'(s) < from) ? 2'(s) : 2'(s + 1);
					other = c;
					other[2*p +: 2] = to;
					if (amino_of(other) == amino_of(c))
						r.syn[p*3 + s] = 1'b1;
					else
						r.nonsyn[p*3 + s] = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/cpa_codon_sum.sv =====
// Per-codon synonymous and non-synonymous probability sums over the nine point mutations.
module cpa_codon_sum import cpa_pkg::*; #(
	parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
	input  logic [5:0]                  codon,
	input  logic [RATE_W-1:0]           rate [CFG_REGS],
	output logic [PROB_FRAC_BITS+3:0]   ps,
	output logic [PROB_FRAC_BITS+3:0]   pn
);

	localparam int PW = (3 * PROB_FRAC_BITS > RATE_W) ? 3 * PROB_FRAC_BITS : RATE_W;
	localparam int SW = PROB_FRAC_BITS + 4;

	mut_class_t                cls;
	logic [1:0]                from;
	logic [PW-1:0]             ext;
	logic [PROB_FRAC_BITS-1:0] field;

	always_comb begin
		cls = mut_class(codon);
		ps = '0;
		pn = '0;
		from = '0;
		ext = '0;
		field = '0;
		for (int p = 0; p < 3; p++) begin
			from = codon[2*p +: 2];
			ext = PW'(rate[from]);
			for (int s = 0; s < 3; s++) begin
				field = ext[s*PROB_FRAC_BITS +: PROB_FRAC_BITS];
				if (cls.syn[p*3 + s])
					ps = ps + SW'(field);
				if (cls.nonsyn[p*3 + s])
					pn = pn + SW'(field);
			end
		end
	end

endmodule

// ===== sv/codon_pn_ps_accumulator.sv =====
// Top level: FASTA byte parser, codon probability accumulator and result register.
//
// Takes one text byte per cycle unless stalled. A line's result is registered through
// s1, s2 and s3 after its closing newline and waits in an output register until taken.
// Input stalls only while a second result is in s3 and the output is full, not taken.
// Rate registers must be written only while the block is idle; this is not enforced.
module codon_pn_ps_accumulator import cpa_pkg::*; #(
	parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF,
	parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           text_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SUM_W-1:0]     nonsyn_sum,
	output logic [SUM_W-1:0]     syn_sum,
	output logic [CNT_OUT_W-1:0] codon_total,
	output logic                 incomplete
);

	localparam int SW = PROB_FRAC_BITS + 4;

	typedef enum logic [2:0] {
		MODE_SEEK = 3'b001,
		MODE_HEAD = 3'b010,
		MODE_SEQ  = 3'b100
	} mode_t;

	logic [RATE_W-1:0] rate_q [CFG_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++)
				rate_q[i] <= '0;
		end else if (cfg_we) begin
			rate_q[cfg_index] <= cfg_data;
		end
	end

	// pipeline control
	logic stall;
	logic adv;

	logic       v_s1;
	logic [7:0] byte_s1;

	logic       codon_v_s2, emit_s2, inc_s2;
	logic [5:0] codon_s2;

	logic          codon_v_s3, emit_s3, inc_s3;
	logic [SW-1:0] ps_s3, pn_s3;

	logic out_valid_q;

	assign stall    = emit_s3 & out_valid_q & ~out_ready;
	assign adv      = ~stall;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid)
			byte_s1 <= text_byte;
	end

	// parser
	mode_t      mode_q, mode_d;
	logic [3:0] partial_q, partial_d;
	logic [1:0] held_q, held_d;
	logic       codon_v_d, emit_d, inc_d;
	logic [5:0] codon_d, shifted;

	always_comb begin
		mode_d    = mode_q;
		partial_d = partial_q;
		held_d    = held_q;
		codon_v_d = 1'b0;
		emit_d    = 1'b0;
		inc_d     = 1'b0;
		shifted   = {partial_q, base_code(byte_s1)};
		codon_d   = shifted;
		case (mode_q)
			MODE_HEAD: begin
				if (byte_s1 == CHR_NL) begin
					mode_d    = MODE_SEQ;
					partial_d = '0;
					held_d    = '0;
				end
			end
			MODE_SEQ: begin
				if (byte_s1 == CHR_NL) begin
					emit_d    = 1'b1;
					inc_d     = (held_q != 2'd0);
					mode_d    = MODE_SEEK;
					partial_d = '0;
					held_d    = '0;
				end else if (held_q == 2'd2) begin
					codon_v_d = 1'b1;
					partial_d = '0;
					held_d    = '0;
				end else begin
					partial_d = shifted[3:0];
					held_d    = held_q + 2'd1;
				end
			end
			default: begin
				if (byte_s1 == CHR_MARK) begin
					mode_d    = MODE_HEAD;
					partial_d = '0;
					held_d    = '0;
				end else begin
					mode_d = MODE_SEEK;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SEEK;
			partial_q  <= '0;
			held_q     <= '0;
			codon_v_s2 <= 1'b0;
			emit_s2    <= 1'b0;
		end else if (adv) begin
			codon_v_s2 <= v_s1 & codon_v_d;
			emit_s2    <= v_s1 & emit_d;
			if (v_s1) begin
				mode_q    <= mode_d;
				partial_q <= partial_d;
				held_q    <= held_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			codon_s2 <= codon_d;
			inc_s2   <= inc_d;
		end
	end

	// per-codon sums
	logic [SW-1:0] ps_d, pn_d;

	cpa_codon_sum #(
		.PROB_FRAC_BITS(PROB_FRAC_BITS)
	) u_sum (
		.codon (codon_s2),
		.rate  (rate_q),
		.ps    (ps_d),
		.pn    (pn_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codon_v_s3 <= 1'b0;
			emit_s3    <= 1'b0;
		end else if (adv) begin
			codon_v_s3 <= codon_v_s2;
			emit_s3    <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ps_s3  <= ps_d;
			pn_s3  <= pn_d;
			inc_s3 <= inc_s2;
		end
	end

	// accumulators, saturating
	logic [SUM_W-1:0]      syn_acc_q, nonsyn_acc_q;
	logic [COUNT_BITS-1:0] codon_acc_q;
	logic [SUM_W:0]        syn_add, nonsyn_add;
	logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_ext;

	assign syn_add    = {1'b0, syn_acc_q} + (SUM_W + 1)'(ps_s3);
	assign nonsyn_add = {1'b0, nonsyn_acc_q} + (SUM_W + 1)'(pn_s3);
	assign cnt_ext    = {{CNT_OUT_W{1'b0}}, codon_acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn_acc_q    <= '0;
			nonsyn_acc_q <= '0;
			codon_acc_q  <= '0;
		end else if (adv) begin
			if (emit_s3) begin
				syn_acc_q    <= '0;
				nonsyn_acc_q <= '0;
				codon_acc_q  <= '0;
			end else if (codon_v_s3) begin
				syn_acc_q    <= syn_add[SUM_W] ? {SUM_W{1'b1}} : syn_add[SUM_W-1:0];
				nonsyn_acc_q <= nonsyn_add[SUM_W] ? {SUM_W{1'b1}} : nonsyn_add[SUM_W-1:0];
				if (!(&codon_acc_q))
					codon_acc_q <= codon_acc_q + COUNT_BITS'(1);
			end
		end
	end

	// result register
	logic [SUM_W-1:0]     nonsyn_sum_q, syn_sum_q;
	logic [CNT_OUT_W-1:0] codon_total_q;
	logic                 incomplete_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s3) begin
			nonsyn_sum_q  <= nonsyn_acc_q;
			syn_sum_q     <= syn_acc_q;
			codon_total_q <= cnt_ext[CNT_OUT_W-1:0];
			incomplete_q  <= inc_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign nonsyn_sum  = nonsyn_sum_q;
	assign syn_sum     = syn_sum_q;
	assign codon_total = codon_total_q;
	assign incomplete  = incomplete_q;

endmodule

// ===== dv/codon_pn_ps_accumulator_test.sv =====
// Self-checking testbench for the codon PN/PS accumulator: FASTA byte stream in, line sums out.
`timescale 1ns / 100ps

module codon_pn_ps_accumulator_test;
	import cpa_pkg::*;

	localparam int PROB_BITS  = PROB_FRAC_BITS_DEF;
	localparam int LONG_HOLD  = 400;
	localparam int PHASE_BYTES = 220;

	localparam logic [CFG_IDX_W-1:0] IDX_RATE_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] IDX_RATE_C = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] IDX_RATE_G = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] IDX_RATE_T = CFG_IDX_W'(3);

	typedef enum logic [1:0] {PS_SEEK, PS_HEADER, PS_SEQUENCE} parse_state_t;

	typedef struct packed {
		logic [SUM_W-1:0]     nonsyn;
		logic [SUM_W-1:0]     syn;
		logic [CNT_OUT_W-1:0] codons;
		logic                 short_line;
	} line_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RATE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           text_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SUM_W-1:0]     nonsyn_sum;
	logic [SUM_W-1:0]     syn_sum;
	logic [CNT_OUT_W-1:0] codon_total;
	logic                 incomplete;

	// standard genetic code, index b1*16 + b2*4 + b3
	string genetic_code = "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";
	string base_chars   = "ACGTacgt";

	logic [7:0]   pending_bytes[$];
	line_result_t line_results[$];

	logic [RATE_W-1:0]    rate_regs[4];
	parse_state_t         parse_state;
	logic [5:0]           codon_bits;
	logic [1:0]           held;
	logic [SUM_W-1:0]     nonsyn_acc;
	logic [SUM_W-1:0]     syn_acc;
	logic [CNT_OUT_W-1:0] codon_acc;

	int  offered_cnt = 0;
	int  accepted_cnt = 0;
	int  mismatches = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_left = 0;
	bit  calm = 1'b0;
	bit  hold_request = 1'b0;
	bit  hold_done = 1'b0;

	codon_pn_ps_accumulator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.nonsyn_sum (nonsyn_sum),
		.syn_sum    (syn_sum),
		.codon_total(codon_total),
		.incomplete (incomplete)
	);

	always #5 clk = ~clk;

	function automatic logic [1:0] base_of(input logic [7:0] b);
		case (b)
			"C", "c": return BASE_C;
			"G", "g": return BASE_G;
			"T", "t": return BASE_T;
			default:  return BASE_A;
		endcase
	endfunction

	function automatic logic [PROB_BITS-1:0] mut_rate(input logic [1:0] src, input logic [1:0] dst);
		int slot;
		slot = (dst < src) ? int'(dst) : int'(dst) - 1;
		return rate_regs[src][slot*PROB_BITS +: PROB_BITS];
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = 64'(a) + b;
		return (s > 64'hFFFF_FFFF_FFFF) ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic void clear_line();
		codon_bits = '0;
		held       = '0;
		nonsyn_acc = '0;
		syn_acc    = '0;
		codon_acc  = '0;
	endfunction

	function automatic void add_codon(input logic [5:0] c);
		logic [63:0] ps;
		logic [63:0] pn;
		logic [5:0]  alt;
		logic [1:0]  src;
		ps = '0;
		pn = '0;
		if (genetic_code[c] != AMINO_STOP) begin
			for (int pos = 0; pos < 3; pos++) begin
				src = c[2*pos +: 2];
				for (int dst = 0; dst < 4; dst++) begin
					if (dst[1:0] != src) begin
						alt = c;
						alt[2*pos +: 2] = dst[1:0];
						if (genetic_code[alt] == genetic_code[c])
							ps += 64'(mut_rate(src, dst[1:0]));
						else
							pn += 64'(mut_rate(src, dst[1:0]));
					end
				end
			end
		end
		syn_acc    = sat_add(syn_acc, ps);
		nonsyn_acc = sat_add(nonsyn_acc, pn);
		if (codon_acc != '1)
			codon_acc = codon_acc + 1'b1;
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		line_result_t r;
		case (parse_state)
			PS_HEADER: begin
				if (b == CHR_NL) begin
					parse_state = PS_SEQUENCE;
					codon_bits  = '0;
					held        = '0;
				end
			end
			PS_SEQUENCE: begin
				if (b == CHR_NL) begin
					r.nonsyn     = nonsyn_acc;
					r.syn        = syn_acc;
					r.codons     = codon_acc;
					r.short_line = (held != 2'd0);
					line_results.push_back(r);
					clear_line();
					parse_state = PS_SEEK;
				end else begin
					codon_bits = {codon_bits[3:0], base_of(b)};
					held = held + 2'd1;
					if (held == 2'd3) begin
						add_codon(codon_bits);
						codon_bits = '0;
						held       = '0;
					end
				end
			end
			default: begin
				if (b == CHR_MARK) begin
					clear_line();
					parse_state = PS_HEADER;
				end else begin
					parse_state = PS_SEEK;
				end
			end
		endcase
	endfunction

	// text sender
	always @(negedge clk) begin
		logic       next_valid;
		logic [7:0] next_byte;
		next_valid = in_valid;
		next_byte  = text_byte;
		if (!in_valid || accepted_cnt == offered_cnt) begin
			next_valid = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				tx_gap = $urandom_range(0, 12);
			end else if (pending_bytes.size() != 0) begin
				next_valid = 1'b1;
				next_byte  = pending_bytes.pop_front();
				offered_cnt++;
			end
		end
		in_valid  <= next_valid;
		text_byte <= next_byte;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			scan_byte(text_byte);
			accepted_cnt++;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			rx_gap = $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result nonsyn %h syn %h codons %0d incomplete %b",
						$time, nonsyn_sum, syn_sum, codon_total, incomplete);
			end else begin
				want = line_results.pop_front();
				if (nonsyn_sum !== want.nonsyn || syn_sum !== want.syn ||
						codon_total !== want.codons || incomplete !== want.short_line) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: mismatch exp nonsyn %h syn %h codons %0d incomplete %b, ",
							"got nonsyn %h syn %h codons %0d incomplete %b"}, $time,
							want.nonsyn, want.syn, want.codons, want.short_line,
							nonsyn_sum, syn_sum, codon_total, incomplete);
				end
			end
		end
	end

	task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		rate_regs[idx] = val;
	endtask

	task automatic set_rates(input logic [RATE_W-1:0] ra, input logic [RATE_W-1:0] rc,
			input logic [RATE_W-1:0] rg, input logic [RATE_W-1:0] rt);
		write_rate(IDX_RATE_A, ra);
		write_rate(IDX_RATE_C, rc);
		write_rate(IDX_RATE_G, rg);
		write_rate(IDX_RATE_T, rt);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RATE_W-1:0] rand_rate();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[RATE_W-1:0];
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_not_nl();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == CHR_NL) ? CHR_MARK : b;
	endfunction

	// one FASTA record with random content; now and then noise or a missing line end
	function automatic int queue_record();
		int n;
		int seq_len;
		n = pending_bytes.size();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				pending_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2))
				pending_bytes.push_back(8'($urandom_range(0, 255)));
			pending_bytes.push_back(CHR_MARK);
			repeat ($urandom_range(0, 6))
				pending_bytes.push_back(rand_not_nl());
			pending_bytes.push_back(CHR_NL);
			seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 30);
			repeat (seq_len) begin
				if ($urandom_range(0, 9) == 0)
					pending_bytes.push_back(rand_not_nl());
				else
					pending_bytes.push_back(base_chars[$urandom_range(0, 7)]);
			end
			if ($urandom_range(0, 11) != 0)
				pending_bytes.push_back(CHR_NL);
		end
		return pending_bytes.size() - n;
	endfunction

	task automatic queue_phase(input int nbytes);
		int queued;
		queued = 0;
		while (queued < nbytes)
			queued += queue_record();
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || offered_cnt != accepted_cnt ||
				line_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int i = 0; i < 4; i++)
			rate_regs[i] = '0;
		parse_state = PS_SEEK;
		clear_line();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_rates(rand_rate(), rand_rate(), rand_rate(), rand_rate());
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		queue_text("Q>\n\n>");
		pending_bytes.push_back(8'hFF);
		queue_text("\nTAAtgc\n>\ng>\rT\n");
		drain();

		set_rates('1, '1, '1, '1);
		queue_phase(PHASE_BYTES);
		drain();

		set_rates(rand_rate(), rand_rate(), rand_rate(), rand_rate());
		hold_request = 1'b1;
		queue_phase(PHASE_BYTES);
		drain();

		set_rates('0, '0, '0, '0);
		queue_phase(PHASE_BYTES);
		drain();

		set_rates(rand_rate(), rand_rate(), rand_rate(), rand_rate());
		calm = 1'b1;
		queue_phase(PHASE_BYTES);
		drain();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
